// ===== rtl/shkf_pkg.sv =====
// Shared constants and types for the string hash key former.
// No dependencies; used by string_hash_key_former by scoped names.
package shkf_pkg;

  // Hash seed and odd multiplier
  localparam logic [63:0] HASH_SEED = 64'd525201411107845655;
  localparam logic [63:0] HASH_MULT = 64'h5bd1e9955bd1e995;
  localparam int unsigned HASH_SHIFT = 47;

  // Key layout: prefix of three characters, then eleven 6-bit groups
  localparam int unsigned GROUP_BITS   = 6;
  localparam logic [6:0]  GROUP_OFFSET = 7'd48;
  localparam int unsigned KEY_LENGTH   = 14;

  // Key character positions
  localparam logic [3:0] IDX_P     = 4'd0;
  localparam logic [3:0] IDX_W     = 4'd1;
  localparam logic [3:0] IDX_DASH  = 4'd2;
  localparam logic [3:0] IDX_LAST  = 4'(KEY_LENGTH - 1);

  // Prefix characters
  localparam logic [6:0] CHAR_P    = 7'h70;
  localparam logic [6:0] CHAR_W    = 7'h77;
  localparam logic [6:0] CHAR_DASH = 7'h2d;

  typedef logic [63:0] hash_t;
  typedef logic [3:0]  key_idx_t;

endpackage

// ===== rtl/string_hash_key_former.sv =====
// String hash key former: running 64-bit multiply/xorshift hash over a byte
// stream and serial emission of a 14-character key on each terminating zero.
// Depends on shkf_pkg.
//
// A nonzero byte updates the hash register when it is accepted; a zero byte
// loads its first key character into the output register on acceptance.
// Throughput: one byte per cycle while no key is pending; a zero byte occupies
// the output register for 14 words, and the input stalls until the last is taken.
// Reset (rst_n low, synchronous): hash returns to the seed, output goes empty.
module string_hash_key_former (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_byte
  // Key stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [6:0] key_char, [70:7] hash_value, [71] zero
  output logic        out_tlast   // key_last
);

  shkf_pkg::hash_t    running_hash_r, running_hash_nxt;
  shkf_pkg::hash_t    hash_out_r, hash_out_nxt;
  shkf_pkg::hash_t    rest_r, rest_nxt;
  shkf_pkg::key_idx_t idx_r, idx_nxt;
  logic [6:0]         key_char_r, key_char_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic               in_fire, out_fire, last_fire, end_byte;
  shkf_pkg::hash_t    mixed, product, stepped;
  logic [63:0]        pp_low;
  logic [31:0]        pp_cross_a, pp_cross_b, cross_sum;
  shkf_pkg::key_idx_t idx_inc;

  // Handshakes; any new input byte waits until the last key word leaves
  assign out_fire  = out_valid_r && out_tready;
  assign last_fire = out_fire && (idx_r == shkf_pkg::IDX_LAST);
  assign in_tready = !out_valid_r || last_fire;
  assign in_fire   = in_tvalid && in_tready;
  assign end_byte  = (in_tdata == 8'd0);

  // Mix in the sign-extended byte
  assign mixed = running_hash_r ^ {{56{in_tdata[7]}}, in_tdata};

  // Product mod 2^64 from three 32x32 partial products
  assign pp_low     = 64'(mixed[31:0]) * 64'(shkf_pkg::HASH_MULT[31:0]);
  assign pp_cross_a = 32'(mixed[63:32] * shkf_pkg::HASH_MULT[31:0]);
  assign pp_cross_b = 32'(mixed[31:0] * shkf_pkg::HASH_MULT[63:32]);
  assign cross_sum  = pp_cross_a + pp_cross_b;
  assign product    = pp_low + {cross_sum, 32'd0};

  // Xorshift
  assign stepped = product ^ (product >> shkf_pkg::HASH_SHIFT);

  // Advance the running hash; restart from the seed on a terminator
  always_comb begin
    running_hash_nxt = running_hash_r;
    if (in_fire) begin
      running_hash_nxt = end_byte ? shkf_pkg::HASH_SEED : stepped;
    end
  end

  // Step the key emitter
  assign idx_inc = idx_r + 4'd1;

  always_comb begin
    out_valid_nxt = out_valid_r;
    idx_nxt       = idx_r;
    key_char_nxt  = key_char_r;
    rest_nxt      = rest_r;
    hash_out_nxt  = hash_out_r;
    if (out_fire) begin
      if (idx_r == shkf_pkg::IDX_LAST) begin
        out_valid_nxt = 1'b0;
      end else begin
        idx_nxt = idx_inc;
        case (idx_inc)
          shkf_pkg::IDX_W:    key_char_nxt = shkf_pkg::CHAR_W;
          shkf_pkg::IDX_DASH: key_char_nxt = shkf_pkg::CHAR_DASH;
          default: begin
            key_char_nxt = 7'(rest_r[shkf_pkg::GROUP_BITS-1:0]) + shkf_pkg::GROUP_OFFSET;
            rest_nxt     = rest_r >> shkf_pkg::GROUP_BITS;
          end
        endcase
      end
    end
    // Load a new key on a terminator
    if (in_fire && end_byte) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = shkf_pkg::IDX_P;
      key_char_nxt  = shkf_pkg::CHAR_P;
      rest_nxt      = running_hash_r;
      hash_out_nxt  = running_hash_r;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_hash_r <= shkf_pkg::HASH_SEED;
      out_valid_r    <= 1'b0;
      idx_r          <= shkf_pkg::IDX_P;
    end else begin
      running_hash_r <= running_hash_nxt;
      out_valid_r    <= out_valid_nxt;
      idx_r          <= idx_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    key_char_r <= key_char_nxt;
    rest_r     <= rest_nxt;
    hash_out_r <= hash_out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, hash_out_r, key_char_r};
  assign out_tlast  = (idx_r == shkf_pkg::IDX_LAST);

  // A terminator starts a key with its first prefix character
  a_key_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && end_byte |=> out_valid_r && key_char_r == shkf_pkg::CHAR_P
                            && idx_r == shkf_pkg::IDX_P)
    else $error("key did not start after terminator");

  // A terminator restarts the running hash from the seed
  a_seed_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && end_byte |=> running_hash_r == shkf_pkg::HASH_SEED)
    else $error("running hash not reseeded");

  // A taken word that is not the last keeps the key going
  a_key_continue: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && idx_r != shkf_pkg::IDX_LAST |=> out_valid_r && idx_r == $past(idx_inc))
    else $error("key emission broke off early");

  // No terminator is taken while a key is still pending
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && end_byte |-> !out_valid_r || last_fire)
    else $error("terminator accepted during key emission");

endmodule

// ===== verif/shkf_key_check_pkg.sv =====
`timescale 1ns / 100ps
// Key tracker for the string hash key former testbench: running-hash predictor
// and queue of expected key words. Self-contained; no RTL package needed.
package shkf_key_check_pkg;

  // Hash constants
  localparam logic [63:0] SEED_HASH  = 64'd525201411107845655;
  localparam logic [63:0] MIX_MULT   = 64'h5bd1e9955bd1e995;
  localparam int unsigned MIX_SHIFT  = 47;
  localparam logic [6:0]  DIGIT_BASE = 7'd48;
  localparam int unsigned NUM_GROUPS = 11;

  // Key prefix characters
  localparam logic [6:0] PREFIX_P    = 7'h70;
  localparam logic [6:0] PREFIX_W    = 7'h77;
  localparam logic [6:0] PREFIX_DASH = 7'h2d;

  typedef struct packed {
    logic [6:0]  key_char;
    logic        key_last;
    logic [63:0] hash_value;
  } key_word_t;

  class hash_key_tracker;
    logic [63:0] string_hash;
    key_word_t   expected_keys[$];
    int unsigned failures;

    function new();
      string_hash = SEED_HASH;
      failures    = 0;
    endfunction

    function int unsigned pending();
      return expected_keys.size();
    endfunction

    // Append one expected key word at the tail
    function void queue_word(key_word_t w);
      expected_keys.insert(expected_keys.size(), w);
    endfunction

    // Fold one accepted byte into the hash, or queue the key on a terminator
    function void note_byte(logic [7:0] char_byte);
      logic [63:0] h;
      logic [63:0] rest;
      key_word_t   w;
      if (char_byte != 8'd0) begin
        h = string_hash ^ {{56{char_byte[7]}}, char_byte};
        h = h * MIX_MULT;
        h = h ^ (h >> MIX_SHIFT);
        string_hash = h;
      end else begin
        w.hash_value = string_hash;
        w.key_last   = 1'b0;
        w.key_char   = PREFIX_P;
        queue_word(w);
        w.key_char   = PREFIX_W;
        queue_word(w);
        w.key_char   = PREFIX_DASH;
        queue_word(w);
        rest = string_hash;
        for (int g = 0; g < NUM_GROUPS; g++) begin
          w.key_char = {1'b0, rest[5:0]} + DIGIT_BASE;
          w.key_last = (g == NUM_GROUPS - 1);
          queue_word(w);
          rest = rest >> 6;
        end
        string_hash = SEED_HASH;
      end
    endfunction

    // Compare one accepted key word with the oldest expectation
    function void check_key_word(logic [6:0] key_char, logic key_last,
                                 logic [63:0] hash_value, logic pad_bit);
      key_word_t w;
      if (expected_keys.size() == 0) begin
        $error("unexpected key word: key_char %h key_last %b hash_value %h",
               key_char, key_last, hash_value);
        failures++;
        return;
      end
      w = expected_keys.pop_front();
      if (key_char !== w.key_char) begin
        $error("key_char: expected %h, actual %h", w.key_char, key_char);
        failures++;
      end
      if (key_last !== w.key_last) begin
        $error("key_last: expected %b, actual %b", w.key_last, key_last);
        failures++;
      end
      if (hash_value !== w.hash_value) begin
        $error("hash_value: expected %h, actual %h", w.hash_value, hash_value);
        failures++;
      end
      if (pad_bit !== 1'b0) begin
        $error("tdata pad bit: expected 0, actual %b", pad_bit);
        failures++;
      end
    endfunction
  endclass

endpackage

// ===== verif/string_hash_key_former_test.sv =====
`timescale 1ns / 100ps
// Top-level testbench for string_hash_key_former: drives byte strings with
// bursty valid and a stalling receiver. Depends on shkf_key_check_pkg and the RTL.
module string_hash_key_former_test;

  localparam int unsigned TARGET_BYTES = 430;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 20;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;   // [6:0] key_char, [70:7] hash_value, [71] zero
  logic        out_tlast;   // key_last

  shkf_key_check_pkg::hash_key_tracker keys;
  int unsigned     burst_left = 0;
  int unsigned     bytes_sent = 0;
  int unsigned     cycle_count = 0;
  int unsigned     ready_phase = 0;
  int unsigned     ready_mode = 0;

  string_hash_key_former uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("string_hash_key_former_test failed");
      $finish;
    end
  end

  // Receiver: switch at random among always-ready, random and periodic stall patterns
  always @(negedge clk) begin
    if (ready_phase % 48 == 0) ready_mode = $urandom_range(0, 3);
    ready_phase++;
    case (ready_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= (ready_phase % 5 == 0);
      default: out_tready <= (ready_phase % 16 >= 12);
    endcase
  end

  // Check every accepted key word
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      keys.check_key_word(out_tdata[6:0], out_tlast, out_tdata[70:7], out_tdata[71]);
  end

  // Send one byte, opening a new burst after a random gap when one runs out
  task automatic send_byte(input logic [7:0] char_byte);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 8);
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= char_byte;
    do @(posedge clk); while (!in_tready);
    keys.note_byte(char_byte);
    bytes_sent++;
  endtask

  // Hold the sender until every queued key word has been taken
  task automatic wait_keys_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (keys.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Random nonzero byte, weighted toward text and high bytes
  function automatic logic [7:0] pick_char();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return 8'($urandom_range(32, 126));
    if (sel < 8) return 8'($urandom_range(128, 255));
    return 8'($urandom_range(1, 255));
  endfunction

  initial begin
    int unsigned len;
    keys = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty string, low and high sign extension, bit toggles, text
    send_byte(8'h00);
    send_byte(8'h01); send_byte(8'h00);
    send_byte(8'h80); send_byte(8'h00);
    send_byte(8'hFF); send_byte(8'h7F); send_byte(8'h00);
    send_byte(8'h55); send_byte(8'hAA); send_byte(8'h0F); send_byte(8'hF0);
    send_byte(8'h00);
    send_byte(8'h68); send_byte(8'h65); send_byte(8'h6C); send_byte(8'h6C);
    send_byte(8'h6F); send_byte(8'h00);
    wait_keys_drained();

    // Random strings, mostly short, a few long, some back-to-back empties
    while (bytes_sent < TARGET_BYTES) begin
      case ($urandom_range(0, 9))
        0: len = 0;
        1: len = $urandom_range(20, 40);
        default: len = $urandom_range(1, 10);
      endcase
      repeat (len) send_byte(pick_char());
      send_byte(8'h00);
      if ($urandom_range(0, 11) == 0) wait_keys_drained();
    end

    // Drain and finish
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (keys.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (keys.failures == 0 && keys.pending() == 0)
      $display("string_hash_key_former_test passed");
    else
      $display("string_hash_key_former_test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/shkf_pkg.sv
rtl/string_hash_key_former.sv
verif/shkf_key_check_pkg.sv
verif/string_hash_key_former_test.sv
